FILE: design/rc2g_pkg.sv
// ----------------------------------------------------------------------------
// RC2 generator package
// Shared constants, types and the permutation table.
// ----------------------------------------------------------------------------
`default_nettype none
package rc2g_pkg;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_BYTES = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNTER_SEED = 1'b1;
   localparam logic [63:0] KEY_RESET = 64'h0706050403020100;
   localparam logic [63:0] SEED_RESET = 64'h0F0E0D0C0B0A0908;

   typedef struct packed {
      logic       we;
      logic [5:0] waddr;
      logic [15:0] wdata;
   } kwrite_type;

   function automatic logic [7:0] pitable(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
         8'hd9,8'h78,8'hf9,8'hc4,8'h19,8'hdd,8'hb5,8'hed,8'h28,8'he9,8'hfd,8'h79,8'h4a,8'ha0,8'hd8,8'h9d,
         8'hc6,8'h7e,8'h37,8'h83,8'h2b,8'h76,8'h53,8'h8e,8'h62,8'h4c,8'h64,8'h88,8'h44,8'h8b,8'hfb,8'ha2,
         8'h17,8'h9a,8'h59,8'hf5,8'h87,8'hb3,8'h4f,8'h13,8'h61,8'h45,8'h6d,8'h8d,8'h09,8'h81,8'h7d,8'h32,
         8'hbd,8'h8f,8'h40,8'heb,8'h86,8'hb7,8'h7b,8'h0b,8'hf0,8'h95,8'h21,8'h22,8'h5c,8'h6b,8'h4e,8'h82,
         8'h54,8'hd6,8'h65,8'h93,8'hce,8'h60,8'hb2,8'h1c,8'h73,8'h56,8'hc0,8'h14,8'ha7,8'h8c,8'hf1,8'hdc,
         8'h12,8'h75,8'hca,8'h1f,8'h3b,8'hbe,8'he4,8'hd1,8'h42,8'h3d,8'hd4,8'h30,8'ha3,8'h3c,8'hb6,8'h26,
         8'h6f,8'hbf,8'h0e,8'hda,8'h46,8'h69,8'h07,8'h57,8'h27,8'hf2,8'h1d,8'h9b,8'hbc,8'h94,8'h43,8'h03,
         8'hf8,8'h11,8'hc7,8'hf6,8'h90,8'hef,8'h3e,8'he7,8'h06,8'hc3,8'hd5,8'h2f,8'hc8,8'h66,8'h1e,8'hd7,
         8'h08,8'he8,8'hea,8'hde,8'h80,8'h52,8'hee,8'hf7,8'h84,8'haa,8'h72,8'hac,8'h35,8'h4d,8'h6a,8'h2a,
         8'h96,8'h1a,8'hd2,8'h71,8'h5a,8'h15,8'h49,8'h74,8'h4b,8'h9f,8'hd0,8'h5e,8'h04,8'h18,8'ha4,8'hec,
         8'hc2,8'he0,8'h41,8'h6e,8'h0f,8'h51,8'hcb,8'hcc,8'h24,8'h91,8'haf,8'h50,8'ha1,8'hf4,8'h70,8'h39,
         8'h99,8'h7c,8'h3a,8'h85,8'h23,8'hb8,8'hb4,8'h7a,8'hfc,8'h02,8'h36,8'h5b,8'h25,8'h55,8'h97,8'h31,
         8'h2d,8'h5d,8'hfa,8'h98,8'he3,8'h8a,8'h92,8'hae,8'h05,8'hdf,8'h29,8'h10,8'h67,8'h6c,8'hba,8'hc9,
         8'hd3,8'h00,8'he6,8'hcf,8'he1,8'h9e,8'ha8,8'h2c,8'h63,8'h16,8'h01,8'h3f,8'h58,8'he2,8'h89,8'ha9,
         8'h0d,8'h38,8'h34,8'h1b,8'hab,8'h33,8'hff,8'hb0,8'hbb,8'h48,8'h0c,8'h5f,8'hb9,8'hb1,8'hcd,8'h2e,
         8'hc5,8'hf3,8'hdb,8'h47,8'he5,8'ha5,8'h9c,8'h77,8'h0a,8'ha6,8'h20,8'h68,8'hfe,8'h7f,8'hc1,8'had};
      return t[a];
   endfunction
endpackage
`default_nettype wire

FILE: design/rc2g_if.sv
// ----------------------------------------------------------------------------
// RC2 generator channels
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface rc2g_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source(output valid, output restart, input ready);
   modport sink(input valid, input restart, output ready);
endinterface

interface rc2g_rsp_if;
   logic valid;
   logic ready;
   logic [63:0] random_block;
   modport source(output valid, output random_block, input ready);
   modport sink(input valid, input random_block, output ready);
endinterface

interface rc2g_csr_if;
   logic valid;
   logic ready;
   logic [rc2g_pkg::CSR_INDEX_W-1:0] index;
   logic [63:0] data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: design/rc2g_key_ram.sv
// ----------------------------------------------------------------------------
// RC2 generator key word memory
// 64 x 16 memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rc2g_key_ram import rc2g_pkg::*; (
   input  wire logic        clock,
   input  wire kwrite_type  wr,
   input  wire logic [5:0]  raddr,
   output logic [15:0]      rdata
);
   logic [15:0] mem [64];
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.waddr] <= wr.wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

FILE: design/rc2g_expander.sv
// ----------------------------------------------------------------------------
// RC2 generator key expander
// Fills the 128-byte expansion memory and writes the 64 key words.
// ----------------------------------------------------------------------------
`default_nettype none
module rc2g_expander import rc2g_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] key,
   output logic             busy,
   output kwrite_type       kwr
);
   localparam logic [2:0] S_IDLE = 3'd0, S_FWD = 3'd1, S_RED = 3'd2,
                          S_BWD = 3'd3, S_PACK = 3'd4;
   logic [2:0] state_ff, state_in;
   logic [7:0] cnt_ff, cnt_in;
   logic [7:0] prev_ff, prev_in;
   logic [7:0] last8_ff [8];
   logic [7:0] last8_in [8];
   logic [7:0] lo_ff, lo_in;
   logic [7:0] mem [128];
   logic       mwe;
   logic [6:0] mwaddr;
   logic [7:0] mwdata;
   logic [7:0] nb;

   // Forward and backward passes only need the eight most recent bytes,
   // kept in a shift line; the memory holds the full sequence for packing.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      prev_in = prev_ff;
      last8_in = last8_ff;
      lo_in = lo_ff;
      mwe = 1'b0;
      mwaddr = cnt_ff[6:0];
      mwdata = 8'h00;
      nb = 8'h00;
      kwr = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_FWD;
               cnt_in = 8'd0;
            end
         end
         S_FWD: begin
            if (cnt_ff < 8'd8) begin
               nb = key[cnt_ff[2:0]*8 +: 8];
            end else begin
               nb = pitable(prev_ff + last8_ff[0]);
            end
            mwe = 1'b1;
            mwdata = nb;
            prev_in = nb;
            for (int i = 0; i < 7; i++) begin
               last8_in[i] = last8_ff[i+1];
            end
            last8_in[7] = nb;
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff == 8'd127) begin
               state_in = S_RED;
            end
         end
         S_RED: begin
            // last8 holds bytes 120..127 oldest first.
            nb = pitable(last8_ff[0]);
            mwe = 1'b1;
            mwaddr = 7'd120;
            mwdata = nb;
            prev_in = nb;
            last8_in[0] = nb;
            cnt_in = 8'd119;
            state_in = S_BWD;
         end
         S_BWD: begin
            // last8[0] is byte i+1, last8[7] byte i+8.
            nb = pitable(last8_ff[0] ^ last8_ff[7]);
            mwe = 1'b1;
            mwdata = nb;
            for (int i = 7; i > 0; i--) begin
               last8_in[i] = last8_ff[i-1];
            end
            last8_in[0] = nb;
            cnt_in = cnt_ff - 8'd1;
            if (cnt_ff == 8'd0) begin
               state_in = S_PACK;
            end
         end
         S_PACK: begin
            // cnt enters at 255 and walks 0..128; read data appears in the cycle after its address.
            if (cnt_ff[0] == 1'b0 && cnt_ff != 8'd0) begin
               kwr.we = 1'b1;
               kwr.waddr = 6'(cnt_ff[7:1] - 7'd1);
               kwr.wdata = {prev_ff, lo_ff};
            end
            if (cnt_ff[0] == 1'b1) begin
               lo_in = prev_ff;
            end
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff == 8'd128) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mwe) begin
         mem[mwaddr] <= mwdata;
      end
      if (state_ff == S_PACK) begin
         prev_ff <= mem[cnt_ff[6:0]];
      end else begin
         prev_ff <= prev_in;
      end
      cnt_ff <= cnt_in;
      last8_ff <= last8_in;
      lo_ff <= lo_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE) || start;

`ifndef NO_ASSERTIONS
   a_fwd_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RED) |-> $past(cnt_ff) == 8'd127)
      else $error("forward pass length wrong");
   a_kw_pack: assert property (@(posedge clock) disable iff (reset)
      kwr.we |-> state_ff == S_PACK)
      else $error("key write outside packing");
   a_bwd_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BWD && cnt_ff == 8'd0) |=> state_ff == S_PACK)
      else $error("backward pass did not end");
`endif
endmodule
`default_nettype wire

FILE: design/rc2g_cipher.sv
// ----------------------------------------------------------------------------
// RC2 generator cipher core
// Mix and mash rounds, one key word read from memory per step.
// ----------------------------------------------------------------------------
`default_nettype none
module rc2g_cipher import rc2g_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] blk,
   output logic [5:0]       raddr,
   input  wire logic [15:0] rdata,
   output logic             done,
   output logic [63:0]      result
);
   // Each step: phase A issues the read, phase B consumes the data.
   logic        run_ff, run_in;
   logic        ph_ff, ph_in;
   logic [3:0]  round_ff, round_in;
   logic [1:0]  word_ff, word_in;
   logic        mash_ff, mash_in;
   logic [15:0] r_ff [4];
   logic [15:0] r_in [4];
   logic [15:0] a, b, c, x, s, rot;
   logic        last;

   always_comb begin
      run_in = run_ff;
      ph_in = ph_ff;
      round_in = round_ff;
      word_in = word_ff;
      mash_in = mash_ff;
      r_in = r_ff;
      done = 1'b0;
      last = 1'b0;
      x = r_ff[word_ff];
      a = r_ff[word_ff - 2'd1];
      b = r_ff[word_ff - 2'd2];
      c = r_ff[word_ff - 2'd3];
      if (mash_ff) begin
         raddr = a[5:0];
      end else begin
         raddr = {round_ff, word_ff};
      end
      s = 16'h0;
      rot = 16'h0;
      if (start) begin
         run_in = 1'b1;
         ph_in = 1'b0;
         round_in = 4'd0;
         word_in = 2'd0;
         mash_in = 1'b0;
         r_in[0] = blk[15:0];
         r_in[1] = blk[31:16];
         r_in[2] = blk[47:32];
         r_in[3] = blk[63:48];
      end else if (run_ff) begin
         if (!ph_ff) begin
            ph_in = 1'b1;
         end else begin
            ph_in = 1'b0;
            if (mash_ff) begin
               r_in[word_ff] = x + rdata;
            end else begin
               s = x + rdata + (a & b) + (~a & c);
               case (word_ff)
                  2'd0: rot = {s[14:0], s[15]};
                  2'd1: rot = {s[13:0], s[15:14]};
                  2'd2: rot = {s[12:0], s[15:13]};
                  default: rot = {s[10:0], s[15:11]};
               endcase
               r_in[word_ff] = rot;
            end
            word_in = word_ff + 2'd1;
            if (word_ff == 2'd3) begin
               if (!mash_ff && (round_ff == 4'd4 || round_ff == 4'd10)) begin
                  mash_in = 1'b1;
               end else begin
                  mash_in = 1'b0;
                  round_in = round_ff + 4'd1;
                  if (round_ff == 4'd15) begin
                     last = 1'b1;
                     run_in = 1'b0;
                  end
               end
            end
         end
      end
      done = last;
      result = {r_in[3], r_in[2], r_in[1], r_in[0]};
   end

   always_ff @(posedge clock) begin
      ph_ff <= ph_in;
      round_ff <= round_in;
      word_ff <= word_in;
      mash_ff <= mash_in;
      r_ff <= r_in;
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_done_run: assert property (@(posedge clock) disable iff (reset)
      done |-> run_ff && round_ff == 4'd15 && word_ff == 2'd3)
      else $error("done outside last step");
   a_mash_rounds: assert property (@(posedge clock) disable iff (reset)
      (run_ff && mash_ff) |-> (round_ff == 4'd4 || round_ff == 4'd10))
      else $error("mash in wrong round");
   a_idle_stable: assert property (@(posedge clock) disable iff (reset)
      (!run_ff && !start) |=> !run_ff)
      else $error("core started without request");
`endif
endmodule
`default_nettype wire

FILE: design/rc2_counter_mode_random_generator_unit.sv
// ----------------------------------------------------------------------------
// RC2 counter-mode random generator
// Top level: registers, counter, key expansion and cipher control.
// ----------------------------------------------------------------------------
// Each request word yields one 64-bit random word. A normal request runs
// 72 key memory steps (64 mix plus 8 mash), each a read phase and a use phase
// on the single read port of the key memory. A restart request, and the first
// request after reset, first runs the key expansion (128 forward bytes, one
// reduced byte, 120 backward bytes, then packing into 64 key words).
`default_nettype none
module rc2_counter_mode_random_generator_unit import rc2g_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   rc2g_req_if.sink   req,
   rc2g_rsp_if.source rsp,
   rc2g_csr_if.sink   csr
);
   localparam logic [1:0] T_IDLE = 2'd0, T_EXP = 2'd1, T_ENC = 2'd2, T_OUT = 2'd3;
   logic [1:0]  state_ff, state_in;
   logic [63:0] key_ff, seed_ff, ctr_ff, ctr_in, out_ff;
   logic        loaded_ff;
   logic        exp_start, exp_busy, enc_start, enc_done;
   logic [63:0] enc_result;
   logic [5:0]  raddr;
   logic [15:0] rdata;
   kwrite_type  kwr;

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == T_IDLE);
   assign rsp.valid = (state_ff == T_OUT);
   assign rsp.random_block = out_ff;

   always_comb begin
      state_in = state_ff;
      exp_start = 1'b0;
      enc_start = 1'b0;
      ctr_in = ctr_ff;
      case (state_ff)
         T_IDLE: begin
            if (req.valid) begin
               if (req.restart || !loaded_ff) begin
                  exp_start = 1'b1;
                  ctr_in = seed_ff;
                  state_in = T_EXP;
               end else begin
                  ctr_in = {ctr_ff[63:32] + 32'd1, ctr_ff[31:0]};
                  enc_start = 1'b1;
                  state_in = T_ENC;
               end
            end
         end
         T_EXP: begin
            if (!exp_busy) begin
               ctr_in = {ctr_ff[63:32] + 32'd1, ctr_ff[31:0]};
               enc_start = 1'b1;
               state_in = T_ENC;
            end
         end
         T_ENC: begin
            if (enc_done) begin
               state_in = T_OUT;
            end
         end
         T_OUT: begin
            if (rsp.ready) begin
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ctr_ff <= ctr_in;
      if (enc_done) begin
         out_ff <= enc_result;
      end
      if (reset) begin
         state_ff <= T_IDLE;
         loaded_ff <= 1'b0;
         key_ff <= KEY_RESET;
         seed_ff <= SEED_RESET;
      end else begin
         state_ff <= state_in;
         if (exp_start) begin
            loaded_ff <= 1'b1;
         end
         if (csr.valid && csr.index == CSR_KEY_BYTES) begin
            key_ff <= csr.data;
         end
         if (csr.valid && csr.index == CSR_COUNTER_SEED) begin
            seed_ff <= csr.data;
         end
      end
   end

   rc2g_expander u_exp (
      .clock(clock), .reset(reset), .start(exp_start), .key(key_ff),
      .busy(exp_busy), .kwr(kwr)
   );
   rc2g_key_ram u_ram (.clock(clock), .wr(kwr), .raddr(raddr), .rdata(rdata));
   rc2g_cipher u_enc (
      .clock(clock), .reset(reset), .start(enc_start), .blk(ctr_in),
      .raddr(raddr), .rdata(rdata), .done(enc_done), .result(enc_result)
   );

`ifndef NO_ASSERTIONS
   a_enc_after: assert property (@(posedge clock) disable iff (reset)
      enc_done |-> state_ff == T_ENC)
      else $error("cipher finished outside encryption");
   a_loaded: assert property (@(posedge clock) disable iff (reset)
      enc_start |-> loaded_ff || exp_start == 1'b0)
      else $error("encryption before key load");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.random_block))
      else $error("response word dropped");
`endif
endmodule
`default_nettype wire
